>>> design/usel_pkg.sv
// Shared types and constants for the upstream selector with backoff.
// Holds the configuration record, the health store command record and
// request and register codes. No dependencies.
package usel_pkg;

  localparam int ADDR_W    = 5;
  localparam int MASK_BITS = 16;

  typedef enum logic [1:0] {
    REQ_SELECT  = 2'd0,
    REQ_FAILURE = 2'd1,
    REQ_SUCCESS = 2'd2,
    REQ_NONE    = 2'd3
  } req_type_t;

  localparam logic [2:0] REG_RR_MODE   = 3'd0;
  localparam logic [2:0] REG_MEMBERS   = 3'd1;
  localparam logic [2:0] REG_BASE_MS   = 3'd2;
  localparam logic [2:0] REG_MAX_MS    = 3'd3;
  localparam logic [2:0] REG_FAIL_CAP  = 3'd4;

  localparam logic [4:0]  RST_MEMBERS  = 5'd1;
  localparam logic [15:0] RST_BASE_MS  = 16'd250;
  localparam logic [23:0] RST_MAX_MS   = 24'd30000;
  localparam logic [3:0]  RST_FAIL_CAP = 4'd8;

  typedef struct packed {
    logic        rr_mode;
    logic [4:0]  member_count;
    logic [15:0] base_ms;
    logic [23:0] max_ms;
    logic [3:0]  fail_cap;
  } cfg_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } mem_cmd_t;

endpackage

>>> design/usel_cfg.sv
// Configuration registers behind an APB-style port.
// Depends on usel_pkg for the register codes and the cfg_t record.
module usel_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [usel_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output usel_pkg::cfg_t              cfg
);
  import usel_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rr_mode      <= 1'b0;
      cfg.member_count <= RST_MEMBERS;
      cfg.base_ms      <= RST_BASE_MS;
      cfg.max_ms       <= RST_MAX_MS;
      cfg.fail_cap     <= RST_FAIL_CAP;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RR_MODE:  cfg.rr_mode      <= pwdata[0];
        REG_MEMBERS:  cfg.member_count <= pwdata[4:0];
        REG_BASE_MS:  cfg.base_ms      <= pwdata[15:0];
        REG_MAX_MS:   cfg.max_ms       <= pwdata[23:0];
        REG_FAIL_CAP: cfg.fail_cap     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RR_MODE:  prdata = {31'd0, cfg.rr_mode};
      REG_MEMBERS:  prdata = {27'd0, cfg.member_count};
      REG_BASE_MS:  prdata = {16'd0, cfg.base_ms};
      REG_MAX_MS:   prdata = {8'd0, cfg.max_ms};
      REG_FAIL_CAP: prdata = {28'd0, cfg.fail_cap};
      default:      prdata = 32'd0;
    endcase
  end

endmodule

>>> design/usel_health_mem.sv
// Per-server health store: failure count and backoff end time.
// One synchronous port with a registered read; valid bits make
// entries read as zero after reset. Depends on usel_pkg for mem_cmd_t.
module usel_health_mem #(
  parameter int MAX_MEMBERS = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  usel_pkg::mem_cmd_t                            cmd,
  input  logic [((MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1)-1:0] addr,
  input  logic [3:0]                                    wr_count,
  input  logic [TIME_BITS-1:0]                          wr_time,
  output logic [3:0]                                    rd_count,
  output logic [TIME_BITS-1:0]                          rd_time
);
  import usel_pkg::*;

  logic [3:0]           cnt_mem  [MAX_MEMBERS];
  logic [TIME_BITS-1:0] time_mem [MAX_MEMBERS];
  logic [MAX_MEMBERS-1:0] vld;
  logic [3:0]           q_cnt;
  logic [TIME_BITS-1:0] q_time;
  logic                 q_vld;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      cnt_mem[addr]  <= wr_count;
      time_mem[addr] <= wr_time;
    end
    if (cmd.rd) begin
      q_cnt  <= cnt_mem[addr];
      q_time <= time_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (cmd.wr) begin
        vld[addr] <= 1'b1;
      end else if (cmd.clr) begin
        vld[addr] <= 1'b0;
      end
      if (cmd.rd) begin
        q_vld <= vld[addr];
      end
    end
  end

  // An entry never written since reset or since a success reads as healthy.
  assign rd_count = q_vld ? q_cnt  : 4'd0;
  assign rd_time  = q_vld ? q_time : '0;

endmodule

>>> design/usel_ctrl.sv
// Request sequencer: start reduction, health store scan for selects,
// and read-modify-write of a server entry for failure reports.
// Depends on usel_pkg; drives usel_health_mem.
module usel_ctrl #(
  parameter int MAX_MEMBERS = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                 clk,
  input  logic                 rst,
  input  usel_pkg::cfg_t       cfg,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type,
  input  logic [47:0]          now_ms,
  input  logic                 take_rr_start,
  input  logic [3:0]           first_server,
  input  logic [15:0]          attempted_mask,
  input  logic [3:0]           member,
  input  logic                 failure_cancelled,
  output logic                 done,
  output logic                 found,
  output logic [3:0]           selected_member,
  output logic                 backoff_probe,
  output logic [23:0]          backoff_ms,
  output usel_pkg::mem_cmd_t   mem_cmd,
  output logic [((MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1)-1:0] mem_addr,
  output logic [3:0]           mem_wr_count,
  output logic [TIME_BITS-1:0] mem_wr_time,
  input  logic [3:0]           mem_rd_count,
  input  logic [TIME_BITS-1:0] mem_rd_time
);
  import usel_pkg::*;

  localparam int IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int CNT_W = $clog2(MAX_MEMBERS + 1);
  localparam int LW    = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_FLEN   = 5'b01000,
    S_FWR    = 5'b10000
  } state_t;

  state_t               state;
  logic [IDX_W-1:0]     rr_pointer;
  logic [LW-1:0]        red;
  logic                 rr_upd;
  logic [IDX_W-1:0]     scan_idx;
  logic [CNT_W-1:0]     rd_left;
  logic                 ev_v;
  logic [IDX_W-1:0]     ev_idx;
  logic                 have_probe;
  logic [IDX_W-1:0]     probe_idx;
  logic [TIME_BITS-1:0] now_q;
  logic [15:0]          mask_q;
  logic [IDX_W-1:0]     mem_idx;
  logic [3:0]           cnt_q;
  logic [23:0]          len_q;

  logic [LW-1:0]        mc_ext;
  logic [CNT_W-1:0]     live_n;
  logic                 accept;
  logic                 in_range;
  logic [LW-1:0]        idx_w;
  logic                 untried;
  logic                 avail;
  logic [3:0]           cap_eff;
  logic [4:0]           cnt_inc;
  logic [3:0]           cnt_new;
  logic [30:0]          shifted;
  logic [23:0]          len_new;
  logic [TIME_BITS:0]   end_sum;

  assign mc_ext   = LW'(cfg.member_count);
  assign live_n   = (mc_ext > LW'(MAX_MEMBERS)) ? CNT_W'(MAX_MEMBERS) : CNT_W'(mc_ext);
  assign busy     = (state != S_IDLE);
  assign accept   = start && (state == S_IDLE);
  assign in_range = LW'(member) < LW'(live_n);

  // Scan evaluation of the entry read in the previous cycle.
  assign idx_w   = LW'(ev_idx);
  assign untried = (idx_w >= LW'(MASK_BITS)) || !mask_q[idx_w[3:0]];
  assign avail   = mem_rd_time <= now_q;

  // Failure update: saturating count, then capped exponential length.
  assign cap_eff = (cfg.fail_cap == 4'd0) ? 4'd1 : cfg.fail_cap;
  assign cnt_inc = {1'b0, mem_rd_count} + 5'd1;
  assign cnt_new = (cnt_inc > {1'b0, cap_eff}) ? cap_eff : cnt_inc[3:0];
  assign shifted = 31'(cfg.base_ms) << (cnt_new - 4'd1);
  assign len_new = (shifted > 31'(cfg.max_ms)) ? cfg.max_ms : shifted[23:0];
  assign end_sum = {1'b0, now_q} + (TIME_BITS + 1)'(len_q);

  assign mem_wr_count = cnt_q;
  assign mem_wr_time  = end_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : end_sum[TIME_BITS-1:0];

  always_comb begin
    mem_cmd.rd  = ((state == S_SCAN) && (rd_left != '0)) ||
                  (accept && (req_type == REQ_FAILURE) && in_range && !failure_cancelled);
    mem_cmd.wr  = (state == S_FWR);
    mem_cmd.clr = accept && (req_type == REQ_SUCCESS) && in_range;
    priority if (state == S_SCAN) begin
      mem_addr = scan_idx;
    end else if (state == S_IDLE) begin
      mem_addr = IDX_W'(member);
    end else begin
      mem_addr = mem_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      rr_pointer      <= '0;
      ev_v            <= 1'b0;
      done            <= 1'b0;
      found           <= 1'b0;
      selected_member <= 4'd0;
      backoff_probe   <= 1'b0;
      backoff_ms      <= 24'd0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            now_q  <= TIME_BITS'(now_ms);
            mask_q <= attempted_mask;
            if ((req_type == REQ_SELECT) && (live_n != '0)) begin
              priority if (!take_rr_start) begin
                red <= LW'(first_server);
              end else if (cfg.rr_mode) begin
                red <= LW'(rr_pointer);
              end else begin
                red <= '0;
              end
              rr_upd <= take_rr_start && cfg.rr_mode;
              state  <= S_REDUCE;
            end else if ((req_type == REQ_FAILURE) && in_range && !failure_cancelled) begin
              mem_idx <= IDX_W'(member);
              state   <= S_FLEN;
            end else begin
              // Ignored reports, successes, selects with no servers and unused
              // request codes complete at once with an all-zero result.
              done            <= 1'b1;
              found           <= 1'b0;
              selected_member <= 4'd0;
              backoff_probe   <= 1'b0;
              backoff_ms      <= 24'd0;
            end
          end
        end
        S_REDUCE: begin
          if (red >= LW'(live_n)) begin
            red <= red - LW'(live_n);
          end else begin
            scan_idx   <= red[IDX_W-1:0];
            rd_left    <= live_n;
            ev_v       <= 1'b0;
            have_probe <= 1'b0;
            if (rr_upd) begin
              rr_pointer <= ((red + LW'(1)) == LW'(live_n)) ? '0 : IDX_W'(red + LW'(1));
            end
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_left != '0) begin
            scan_idx <= ((CNT_W'(scan_idx) + CNT_W'(1)) == live_n) ? '0
                                                                   : scan_idx + IDX_W'(1);
            rd_left  <= rd_left - CNT_W'(1);
          end
          ev_v   <= (rd_left != '0);
          ev_idx <= scan_idx;
          if (ev_v) begin
            if (untried && avail) begin
              done            <= 1'b1;
              found           <= 1'b1;
              selected_member <= 4'(ev_idx);
              backoff_probe   <= 1'b0;
              backoff_ms      <= 24'd0;
              ev_v            <= 1'b0;
              state           <= S_IDLE;
            end else begin
              if (untried && !have_probe) begin
                have_probe <= 1'b1;
                probe_idx  <= ev_idx;
              end
              if (rd_left == '0) begin
                // Last entry seen: fall back to the first untried server.
                done            <= 1'b1;
                found           <= have_probe || untried;
                selected_member <= have_probe ? 4'(probe_idx) :
                                   (untried ? 4'(ev_idx) : 4'd0);
                backoff_probe   <= have_probe || untried;
                backoff_ms      <= 24'd0;
                ev_v            <= 1'b0;
                state           <= S_IDLE;
              end
            end
          end
        end
        S_FLEN: begin
          cnt_q <= cnt_new;
          len_q <= len_new;
          state <= S_FWR;
        end
        S_FWR: begin
          done            <= 1'b1;
          found           <= 1'b0;
          selected_member <= 4'd0;
          backoff_probe   <= 1'b0;
          backoff_ms      <= len_q;
          state           <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/upstream_select_with_backoff.sv
// Channel    | Handshake                       | Payload
// config     | psel/penable/pwrite, pready = 1 | paddr, pwdata, prdata
// request    | start while busy is low         | req_type .. failure_cancelled
// result     | done, one cycle, no stall       | found, selected_member, backoff_probe, backoff_ms
//
// A select first makes R subtractions of the server count n from the
// start position, then one health store read per server, the
// single read port setting the pace; a hit ends the scan early.
// A failure report goes through read, length and write back; other items end at once.
// Reset restores the register defaults and clears the store's valid bits.
// The result follows the last cycle of work; the receiver cannot stall it.
module upstream_select_with_backoff #(
  parameter int MAX_MEMBERS = 16,
  parameter int TIME_BITS   = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [usel_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type,
  input  logic [47:0]                 now_ms,
  input  logic                        take_rr_start,
  input  logic [3:0]                  first_server,
  input  logic [15:0]                 attempted_mask,
  input  logic [3:0]                  member,
  input  logic                        failure_cancelled,
  output logic                        done,
  output logic                        found,
  output logic [3:0]                  selected_member,
  output logic                        backoff_probe,
  output logic [23:0]                 backoff_ms
);
  import usel_pkg::*;

  localparam int IDX_W = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

  cfg_t                 cfg;
  mem_cmd_t             mem_cmd;
  logic [IDX_W-1:0]     mem_addr;
  logic [3:0]           mem_wr_count;
  logic [TIME_BITS-1:0] mem_wr_time;
  logic [3:0]           mem_rd_count;
  logic [TIME_BITS-1:0] mem_rd_time;

  usel_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  usel_health_mem #(
    .MAX_MEMBERS (MAX_MEMBERS),
    .TIME_BITS   (TIME_BITS)
  ) u_mem (
    .clk      (clk),
    .rst      (rst),
    .cmd      (mem_cmd),
    .addr     (mem_addr),
    .wr_count (mem_wr_count),
    .wr_time  (mem_wr_time),
    .rd_count (mem_rd_count),
    .rd_time  (mem_rd_time)
  );

  usel_ctrl #(
    .MAX_MEMBERS (MAX_MEMBERS),
    .TIME_BITS   (TIME_BITS)
  ) u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .start             (start),
    .busy              (busy),
    .req_type          (req_type),
    .now_ms            (now_ms),
    .take_rr_start     (take_rr_start),
    .first_server      (first_server),
    .attempted_mask    (attempted_mask),
    .member            (member),
    .failure_cancelled (failure_cancelled),
    .done              (done),
    .found             (found),
    .selected_member   (selected_member),
    .backoff_probe     (backoff_probe),
    .backoff_ms        (backoff_ms),
    .mem_cmd           (mem_cmd),
    .mem_addr          (mem_addr),
    .mem_wr_count      (mem_wr_count),
    .mem_wr_time       (mem_wr_time),
    .mem_rd_count      (mem_rd_count),
    .mem_rd_time       (mem_rd_time)
  );

endmodule

>>> design/usel_checker.sv
// Port-level checks for upstream_select_with_backoff, bound to the top.
// Depends only on the top level's ports.
module usel_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        found,
  input logic [3:0]  selected_member,
  input logic        backoff_probe,
  input logic [23:0] backoff_ms
);

  // An accepted item either completes at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted item neither completed nor kept the block busy");

  // The result is shown only once the block has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Every end of a busy stretch comes with a result strobe.
  a_busy_end_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // A selection that found nothing carries no server and no probe flag.
  a_none_clean: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (selected_member == 4'd0 && !backoff_probe))
    else $error("empty selection carries a server");

  // A backoff length only comes with a failure report.
  a_backoff_alone: assert property (@(posedge clk) disable iff (rst)
    (done && backoff_ms != 24'd0) |-> (!found && !backoff_probe))
    else $error("backoff length mixed with a selection");

endmodule

bind upstream_select_with_backoff usel_checker u_usel_checker (.*);

>>> tb/testbench.sv
// Self-checking testbench for upstream_select_with_backoff.
// Drives items over start/busy and registers over APB, predicts every
// result in-line and checks it field by field. Depends on usel_pkg only.
`timescale 1ns / 100ps

module testbench;
  import usel_pkg::*;

  typedef struct packed {
    req_type_t   kind;
    logic [47:0] now;
    logic        take_rr;
    logic [3:0]  start_idx;
    logic [15:0] tried;
    logic [3:0]  member;
    logic        cancelled;
  } request_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  member;
    logic        probe;
    logic [23:0] backoff;
  } outcome_t;

  typedef enum logic [1:0] {SESS_NEW, SESS_REPORT, SESS_RETRY} session_t;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                start;
  logic                busy;
  logic [1:0]          req_type;
  logic [47:0]         now_ms;
  logic                take_rr_start;
  logic [3:0]          first_server;
  logic [15:0]         attempted_mask;
  logic [3:0]          member;
  logic                failure_cancelled;
  logic                done;
  logic                found;
  logic [3:0]          selected_member;
  logic                backoff_probe;
  logic [23:0]         backoff_ms;

  upstream_select_with_backoff dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy),
    .req_type(req_type), .now_ms(now_ms), .take_rr_start(take_rr_start),
    .first_server(first_server), .attempted_mask(attempted_mask),
    .member(member), .failure_cancelled(failure_cancelled),
    .done(done), .found(found), .selected_member(selected_member),
    .backoff_probe(backoff_probe), .backoff_ms(backoff_ms)
  );

  // Shadow copy of the registers and of the health store.
  logic        cfg_rr_mode;
  logic [4:0]  cfg_members;
  logic [15:0] cfg_base;
  logic [23:0] cfg_max;
  logic [3:0]  cfg_cap;
  int unsigned fail_cnt [16];
  logic [47:0] healthy_at [16];
  int unsigned rr_ptr;

  outcome_t    awaited [$];
  outcome_t    scratch;
  outcome_t    want;
  logic [47:0] wall_ms;
  bit          gaps_on;
  int          errors;
  int          n_items, n_select, n_probe, n_none, n_backoff, n_cleared, n_settings;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #10_000_000;
    $display("Timeout with %0d results still awaited.", awaited.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void rq_clear();
    errors     = 0;
    n_items    = 0;
    n_select   = 0;
    n_probe    = 0;
    n_none     = 0;
    n_backoff  = 0;
    n_cleared  = 0;
    n_settings = 0;
    wall_ms    = '0;
    gaps_on    = 1'b1;
  endfunction

  function automatic request_t req_of(req_type_t kind, logic [47:0] now, logic take_rr,
                                      logic [3:0] start_idx, logic [15:0] tried,
                                      logic [3:0] m, logic cancelled);
    request_t rq;
    rq.kind      = kind;
    rq.now       = now;
    rq.take_rr   = take_rr;
    rq.start_idx = start_idx;
    rq.tried     = tried;
    rq.member    = m;
    rq.cancelled = cancelled;
    return rq;
  endfunction

  // Computes the result of one item and applies its effect on the health store.
  function automatic outcome_t apply_request(request_t rq);
    outcome_t    o;
    int unsigned n, first, idx, off, cnt, cap_eff;
    logic [63:0] span, until_ms;
    o = '0;
    n = (cfg_members > 16) ? 16 : cfg_members;
    case (rq.kind)
      REQ_SELECT: begin
        if (n != 0) begin
          if (!rq.take_rr) begin
            first = rq.start_idx % n;
          end else if (cfg_rr_mode) begin
            first = rr_ptr % n;
            rr_ptr = (first + 1) % n;
          end else begin
            first = 0;
          end
          for (off = 0; off < n && !o.found; off++) begin
            idx = (first + off) % n;
            if (!rq.tried[idx] && healthy_at[idx] <= rq.now) begin
              o.found  = 1'b1;
              o.member = 4'(idx);
            end
          end
          // Everything untried is backing off: fall back to a probe.
          for (off = 0; off < n && !o.found; off++) begin
            idx = (first + off) % n;
            if (!rq.tried[idx]) begin
              o.found  = 1'b1;
              o.member = 4'(idx);
              o.probe  = 1'b1;
            end
          end
        end
      end
      REQ_FAILURE: begin
        if (rq.member < n && !rq.cancelled) begin
          cap_eff = (cfg_cap == 0) ? 1 : cfg_cap;
          cnt = fail_cnt[rq.member] + 1;
          if (cnt > cap_eff) cnt = cap_eff;
          fail_cnt[rq.member] = cnt;
          span = 64'(cfg_base) << (cnt - 1);
          if (span > 64'(cfg_max)) span = 64'(cfg_max);
          until_ms = 64'(rq.now) + span;
          if (until_ms > 64'hFFFF_FFFF_FFFF) until_ms = 64'hFFFF_FFFF_FFFF;
          healthy_at[rq.member] = until_ms[47:0];
          o.backoff = span[23:0];
        end
      end
      REQ_SUCCESS: begin
        if (rq.member < n) begin
          fail_cnt[rq.member]   = 0;
          healthy_at[rq.member] = '0;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Tasks below start and end at a falling edge.
  task automatic wait_idle();
    start = 1'b0;
    while (awaited.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    wait_idle();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_RR_MODE:  cfg_rr_mode = value[0];
      REG_MEMBERS:  cfg_members = value[4:0];
      REG_BASE_MS:  cfg_base    = value[15:0];
      REG_MAX_MS:   cfg_max     = value[23:0];
      REG_FAIL_CAP: cfg_cap     = value[3:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic send_request(input request_t rq, output outcome_t res);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    req_type          = rq.kind;
    now_ms            = rq.now;
    take_rr_start     = rq.take_rr;
    first_server      = rq.start_idx;
    attempted_mask    = rq.tried;
    member            = rq.member;
    failure_cancelled = rq.cancelled;
    start             = 1'b1;
    do @(posedge clk); while (busy);
    res = apply_request(rq);
    awaited.insert(awaited.size(), res);
    n_items++;
    if (rq.kind == REQ_SELECT) begin
      n_select++;
      if (res.probe) n_probe++;
      if (!res.found) n_none++;
    end
    if (res.backoff != 0) n_backoff++;
    if (rq.kind == REQ_SUCCESS) n_cleared++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited.size() == 0) begin
        $error("result strobe with no item outstanding");
        errors++;
      end else begin
        want = awaited.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          errors++;
        end
        if (selected_member !== want.member) begin
          $error("selected_member: expected %0d, got %0d", want.member, selected_member);
          errors++;
        end
        if (backoff_probe !== want.probe) begin
          $error("backoff_probe: expected %0d, got %0d", want.probe, backoff_probe);
          errors++;
        end
        if (backoff_ms !== want.backoff) begin
          $error("backoff_ms: expected %0d, got %0d", want.backoff, backoff_ms);
          errors++;
        end
      end
    end
  end

  task automatic test_defaults();
    send_request(req_of(REQ_SELECT, 48'd0, 1'b1, 4'd0, 16'h0000, 4'd0, 1'b0), scratch);
    send_request(req_of(REQ_FAILURE, 48'd1000, 1'b0, 4'd0, 16'h0000, 4'd0, 1'b0), scratch);
    // Server 1 is beyond the count, and a cancellation changes nothing.
    send_request(req_of(REQ_FAILURE, 48'd1000, 1'b0, 4'd0, 16'h0000, 4'd1, 1'b0), scratch);
    send_request(req_of(REQ_FAILURE, 48'd1000, 1'b0, 4'd0, 16'h0000, 4'd0, 1'b1), scratch);
    send_request(req_of(REQ_SELECT, 48'd1249, 1'b1, 4'd0, 16'h0000, 4'd0, 1'b0), scratch);
    send_request(req_of(REQ_SELECT, 48'd1250, 1'b1, 4'd0, 16'h0000, 4'd0, 1'b0), scratch);
    send_request(req_of(REQ_SELECT, 48'd1300, 1'b1, 4'd0, 16'h0001, 4'd0, 1'b0), scratch);
    send_request(req_of(REQ_SUCCESS, 48'd1300, 1'b0, 4'd0, 16'h0000, 4'd0, 1'b0), scratch);
    send_request(req_of(REQ_NONE, 48'hFFFF_FFFF_FFFF, 1'b1, 4'hF, 16'hFFFF, 4'd0, 1'b1),
                 scratch);
  endtask

  task automatic test_scan_order();
    write_reg(REG_MEMBERS, 32'd16);
    send_request(req_of(REQ_SELECT, 48'd2000, 1'b0, 4'd15, 16'h7FFF, 4'd0, 1'b0), scratch);
    send_request(req_of(REQ_SELECT, 48'd2000, 1'b0, 4'd15, 16'h8000, 4'd0, 1'b0), scratch);
    send_request(req_of(REQ_SELECT, 48'd2000, 1'b0, 4'd6, 16'hFFFF, 4'd0, 1'b0), scratch);
  endtask

  task automatic test_round_robin();
    write_reg(REG_RR_MODE, 32'd1);
    write_reg(REG_MEMBERS, 32'd5);
    send_request(req_of(REQ_SELECT, 48'd3000, 1'b1, 4'd9, 16'h0000, 4'd0, 1'b0), scratch);
    // The pointer moves on even when nothing can be chosen.
    send_request(req_of(REQ_SELECT, 48'd3000, 1'b1, 4'd0, 16'hFFFF, 4'd0, 1'b0), scratch);
    send_request(req_of(REQ_SELECT, 48'd3000, 1'b0, 4'd12, 16'h0000, 4'd0, 1'b0), scratch);
  endtask

  task automatic test_backoff_growth();
    int k;
    write_reg(REG_MEMBERS, 32'd16);
    write_reg(REG_BASE_MS, 32'd65535);
    write_reg(REG_MAX_MS, 32'hFF_FFFF);
    write_reg(REG_FAIL_CAP, 32'd3);
    for (k = 0; k < 4; k++)
      send_request(req_of(REQ_FAILURE, 48'd5000, 1'b0, 4'd0, 16'h0000, 4'd3, 1'b0), scratch);
    // A count above the lowered cap drops to the cap; a zero cap acts as one.
    write_reg(REG_FAIL_CAP, 32'd1);
    send_request(req_of(REQ_FAILURE, 48'd6000, 1'b0, 4'd0, 16'h0000, 4'd3, 1'b0), scratch);
    write_reg(REG_FAIL_CAP, 32'd0);
    send_request(req_of(REQ_FAILURE, 48'd6000, 1'b0, 4'd0, 16'h0000, 4'd3, 1'b0), scratch);
    write_reg(REG_FAIL_CAP, 32'd15);
    send_request(req_of(REQ_FAILURE, 48'hFFFF_FFFF_FFF0, 1'b0, 4'd0, 16'h0000, 4'd3, 1'b0),
                 scratch);
    send_request(req_of(REQ_SELECT, 48'hFFFF_FFFF_FFFF, 1'b0, 4'd3, 16'hFFF7, 4'd0, 1'b0),
                 scratch);
  endtask

  task automatic test_member_count_edges();
    write_reg(REG_MEMBERS, 32'd0);
    send_request(req_of(REQ_SELECT, 48'd7000, 1'b1, 4'd0, 16'h0000, 4'd0, 1'b0), scratch);
    send_request(req_of(REQ_FAILURE, 48'd7000, 1'b0, 4'd0, 16'h0000, 4'd0, 1'b0), scratch);
    send_request(req_of(REQ_SUCCESS, 48'd7000, 1'b0, 4'd0, 16'h0000, 4'd3, 1'b0), scratch);
    write_reg(REG_MEMBERS, 32'd31);
    send_request(req_of(REQ_SELECT, 48'd7000, 1'b0, 4'd15, 16'h7FFF, 4'd0, 1'b0), scratch);
  endtask

  task automatic randomize_settings();
    int pick;
    pick = $urandom_range(0, 19);
    write_reg(REG_RR_MODE, 32'($urandom_range(0, 1)));
    write_reg(REG_MEMBERS, pick == 0 ? 32'd0 : pick == 1 ? 32'($urandom_range(17, 31)) :
                           pick < 6 ? 32'd16 : pick == 6 ? 32'd1 :
                           32'($urandom_range(2, 15)));
    pick = $urandom_range(0, 9);
    write_reg(REG_BASE_MS, pick == 0 ? 32'd65535 : pick == 1 ? 32'd1 :
                           32'($urandom_range(1, 2000)));
    pick = $urandom_range(0, 9);
    write_reg(REG_MAX_MS, pick == 0 ? 32'hFF_FFFF : pick == 1 ? 32'($urandom_range(0, 100)) :
                          32'($urandom_range(1000, 200000)));
    write_reg(REG_FAIL_CAP, 32'($urandom_range(0, 15)));
    n_settings++;
  endtask

  // Mostly complete client requests: select, report, retry the rest; some noise.
  task automatic test_random_traffic(input int count, input bit gaps);
    int          i, live;
    session_t    step;
    outcome_t    got;
    request_t    rq;
    logic [15:0] tried;
    logic [3:0]  last_pick;
    randomize_settings();
    gaps_on   = gaps;
    step      = SESS_NEW;
    tried     = '0;
    last_pick = '0;
    live      = (cfg_members > 16) ? 16 : cfg_members;
    for (i = 0; i < count; i++) begin
      wall_ms = wall_ms + 48'($urandom_range(0, 400));
      if ($urandom_range(0, 60) == 0) wait_idle();
      if ($urandom_range(0, 99) < 15) begin
        rq = req_of(req_type_t'($urandom_range(0, 3)),
                    $urandom_range(0, 1) ? {16'($urandom), 32'($urandom)} : wall_ms,
                    1'($urandom), 4'($urandom), 16'($urandom), 4'($urandom), 1'($urandom));
        send_request(rq, got);
      end else begin
        case (step)
          SESS_NEW: begin
            tried = '0;
            send_request(req_of(REQ_SELECT, wall_ms, 1'b1, 4'($urandom),
                                16'($urandom) << live, 4'($urandom), 1'b0), got);
            step = got.found ? SESS_REPORT : SESS_NEW;
          end
          SESS_REPORT: begin
            if ($urandom_range(0, 99) < 60) begin
              send_request(req_of(REQ_FAILURE, wall_ms, 1'b0, 4'($urandom), 16'($urandom),
                                  last_pick, $urandom_range(0, 7) == 0), got);
              step = ($urandom_range(0, 9) == 0) ? SESS_NEW : SESS_RETRY;
            end else begin
              send_request(req_of(REQ_SUCCESS, wall_ms, 1'($urandom), 4'($urandom),
                                  16'($urandom), last_pick, 1'($urandom)), got);
              step = SESS_NEW;
            end
          end
          default: begin
            send_request(req_of(REQ_SELECT, wall_ms, 1'b0, last_pick + 4'd1,
                                tried | (16'($urandom) << live), 4'($urandom), 1'b0), got);
            step = got.found ? SESS_REPORT : SESS_NEW;
          end
        endcase
        if (got.found) begin
          last_pick        = got.member;
          tried[got.member] = 1'b1;
        end
      end
    end
  endtask

  initial begin
    int ph;
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; req_type = '0; now_ms = '0; take_rr_start = 1'b0;
    first_server = '0; attempted_mask = '0; member = '0; failure_cancelled = 1'b0;
    cfg_rr_mode = 1'b0;
    cfg_members = RST_MEMBERS;
    cfg_base    = RST_BASE_MS;
    cfg_max     = RST_MAX_MS;
    cfg_cap     = RST_FAIL_CAP;
    for (int j = 0; j < 16; j++) begin
      fail_cnt[j]   = 0;
      healthy_at[j] = '0;
    end
    rr_ptr = 0;
    rq_clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_defaults();
    test_scan_order();
    test_round_robin();
    test_backoff_growth();
    test_member_count_edges();
    for (ph = 0; ph < 7; ph++) test_random_traffic(103, $urandom_range(0, 2) != 0);
    test_random_traffic(103, 1'b0);

    wait_idle();
    repeat (40) @(posedge clk);
    $display("Ran %0d items over %0d random register settings plus directed ones.",
             n_items, n_settings);
    $display("Selects %0d (probes %0d, none %0d), backoffs applied %0d, success reports %0d.",
             n_select, n_probe, n_none, n_backoff, n_cleared);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
